@@ rtl/rpj_pkg.sv @@
`timescale 1ns / 1ps

package rpj_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COORD_W    = 32;
   localparam int COLOR_W    = 24;
   localparam int PROD_W     = 41;
   localparam int W_W        = 42;
   localparam int WMAG_W     = 41;
   localparam int REM_W      = WMAG_W + 1;
   localparam int QUO_W      = COORD_W + 1;

   localparam logic [COORD_W-1:0] COORD_POS_MAX = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] COORD_NEG_MAX = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X         = 3'd0,
      CSR_OFFSET_Y         = 3'd1,
      CSR_FOCAL_LENGTH     = 3'd2,
      CSR_INVERSE_BASELINE = 3'd3,
      CSR_PRINCIPAL_SHIFT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  disparity;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic [COLOR_W-1:0]        packed_color;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic               w_zero;
      logic [2:0]         neg;
      logic [2:0]         num_zero;
      logic [COLOR_W-1:0] color;
   } cell_ctl_type;

endpackage

@@ rtl/rpj_front.sv @@
`timescale 1ns / 1ps

module rpj_front #(
   parameter int FRAC_BITS = rpj_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   req_valid,
   input  rpj_pkg::req_type                       req,
   output logic                                   req_ready,
   input  logic signed [rpj_pkg::CSR_DATA_W-1:0]  offset_x,
   input  logic signed [rpj_pkg::CSR_DATA_W-1:0]  offset_y,
   input  logic signed [rpj_pkg::CSR_DATA_W-1:0]  focal_length,
   input  logic signed [rpj_pkg::CSR_DATA_W-1:0]  inverse_baseline,
   input  logic signed [rpj_pkg::CSR_DATA_W-1:0]  principal_shift,
   output rpj_pkg::cell_ctl_type                  out_ctl,
   output logic [rpj_pkg::WMAG_W-1:0]             out_divisor,
   output logic [2:0][((13 + FRAC_BITS) > 32 ? 13 + FRAC_BITS : 32) + FRAC_BITS:0] out_div
);
   import rpj_pkg::*;

   localparam int NUM_W = ((13 + FRAC_BITS) > 32 ? 13 + FRAC_BITS : 32) + 1;
   localparam int DIV_W = NUM_W + FRAC_BITS;

   logic                     s0_valid_ff, s0_valid_in;
   req_type                  s0_req_ff, s0_req_in;

   logic                     a_valid_ff;
   logic signed [PROD_W-1:0] a_prod_ff, a_prod_in;
   logic signed [NUM_W-1:0]  a_nx_ff, a_nx_in, a_ny_ff, a_ny_in;
   logic [COLOR_W-1:0]       a_color_ff;

   logic                     b_valid_ff;
   logic signed [W_W-1:0]    b_w_ff, b_w_in;
   logic [2:0][NUM_W-1:0]    b_mag_ff, b_mag_in;
   logic [2:0]               b_neg_ff, b_neg_in, b_zero_ff, b_zero_in;
   logic [COLOR_W-1:0]       b_color_ff;

   cell_ctl_type             c_ctl_ff, c_ctl_in;
   logic [WMAG_W-1:0]        c_divisor_ff, c_divisor_in;
   logic [2:0][DIV_W-1:0]    c_div_ff, c_div_in;

   logic signed [PROD_W-1:0] disp_ext, ib_ext;
   logic signed [NUM_W-1:0]  col_ext, row_ext, offx_ext, offy_ext;
   logic [2:0][NUM_W-1:0]    num;
   logic signed [W_W-1:0]    w_neg;

   assign req_ready = advance || !s0_valid_ff;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_req_in   = s0_req_ff;
      if (req_ready) begin
         s0_valid_in = req_valid && (req.disparity != '0);
         s0_req_in   = req;
      end
   end

   always_comb begin
      disp_ext  = $signed({{(PROD_W - 8){1'b0}}, s0_req_ff.disparity});
      ib_ext    = $signed({{(PROD_W - CSR_DATA_W){inverse_baseline[CSR_DATA_W-1]}},
                           inverse_baseline});
      a_prod_in = disp_ext * ib_ext;
      col_ext   = $signed({{(NUM_W - 12 - FRAC_BITS){1'b0}}, s0_req_ff.column,
                           {FRAC_BITS{1'b0}}});
      row_ext   = $signed({{(NUM_W - 12 - FRAC_BITS){1'b0}}, s0_req_ff.row,
                           {FRAC_BITS{1'b0}}});
      offx_ext  = $signed({{(NUM_W - CSR_DATA_W){offset_x[CSR_DATA_W-1]}}, offset_x});
      offy_ext  = $signed({{(NUM_W - CSR_DATA_W){offset_y[CSR_DATA_W-1]}}, offset_y});
      a_nx_in   = col_ext + offx_ext;
      a_ny_in   = row_ext + offy_ext;
   end

   always_comb begin
      b_w_in = $signed({{(W_W - CSR_DATA_W){principal_shift[CSR_DATA_W-1]}},
                        principal_shift})
             - $signed({a_prod_ff[PROD_W-1], a_prod_ff});
      num[0] = a_nx_ff;
      num[1] = a_ny_ff;
      num[2] = {{(NUM_W - CSR_DATA_W){focal_length[CSR_DATA_W-1]}}, focal_length};
      for (int i = 0; i < 3; i++) begin
         b_mag_in[i]  = num[i][NUM_W-1] ? (~num[i] + 1'b1) : num[i];
         b_neg_in[i]  = num[i][NUM_W-1] ^ b_w_in[W_W-1];
         b_zero_in[i] = (num[i] == '0);
      end
   end

   always_comb begin
      w_neg              = -b_w_ff;
      c_ctl_in.valid     = b_valid_ff;
      c_ctl_in.w_zero    = (b_w_ff == '0);
      c_ctl_in.neg       = b_neg_ff;
      c_ctl_in.num_zero  = b_zero_ff;
      c_ctl_in.color     = b_color_ff;
      c_divisor_in       = b_w_ff[W_W-1] ? w_neg[WMAG_W-1:0] : b_w_ff[WMAG_W-1:0];
      for (int i = 0; i < 3; i++) begin
         c_div_in[i] = {b_mag_ff[i], {FRAC_BITS{1'b0}}};
      end
      if (reset) begin
         c_ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s0_req_ff <= s0_req_in;
      if (advance) begin
         a_prod_ff    <= a_prod_in;
         a_nx_ff      <= a_nx_in;
         a_ny_ff      <= a_ny_in;
         a_color_ff   <= {s0_req_ff.red, s0_req_ff.green, s0_req_ff.blue};
         b_w_ff       <= b_w_in;
         b_mag_ff     <= b_mag_in;
         b_neg_ff     <= b_neg_in;
         b_zero_ff    <= b_zero_in;
         b_color_ff   <= a_color_ff;
         c_divisor_ff <= c_divisor_in;
         c_div_ff     <= c_div_in;
      end
      if (advance || reset) begin
         c_ctl_ff <= c_ctl_in;
      end
      if (reset) begin
         s0_valid_ff    <= 1'b0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         if (advance) begin
            a_valid_ff <= s0_valid_ff;
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   assign out_ctl     = c_ctl_ff;
   assign out_divisor = c_divisor_ff;
   assign out_div     = c_div_ff;

endmodule

@@ rtl/rpj_div_cell.sv @@
`timescale 1ns / 1ps

module rpj_div_cell #(
   parameter int FRAC_BITS = rpj_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  rpj_pkg::cell_ctl_type                  in_ctl,
   input  logic [rpj_pkg::WMAG_W-1:0]             in_divisor,
   input  logic [2:0][rpj_pkg::REM_W-1:0]         in_rem,
   input  logic [2:0][((13 + FRAC_BITS) > 32 ? 13 + FRAC_BITS : 32) + FRAC_BITS:0] in_div,
   input  logic [2:0][rpj_pkg::QUO_W-1:0]         in_quo,
   input  logic [2:0]                             in_ovf,
   output rpj_pkg::cell_ctl_type                  out_ctl,
   output logic [rpj_pkg::WMAG_W-1:0]             out_divisor,
   output logic [2:0][rpj_pkg::REM_W-1:0]         out_rem,
   output logic [2:0][((13 + FRAC_BITS) > 32 ? 13 + FRAC_BITS : 32) + FRAC_BITS:0] out_div,
   output logic [2:0][rpj_pkg::QUO_W-1:0]         out_quo,
   output logic [2:0]                             out_ovf
);
   import rpj_pkg::*;

   localparam int NUM_W = ((13 + FRAC_BITS) > 32 ? 13 + FRAC_BITS : 32) + 1;
   localparam int DIV_W = NUM_W + FRAC_BITS;

   cell_ctl_type          ctl_ff, ctl_in;
   logic [WMAG_W-1:0]     divisor_ff;
   logic [2:0][REM_W-1:0] rem_ff, rem_in;
   logic [2:0][DIV_W-1:0] div_ff, div_in;
   logic [2:0][QUO_W-1:0] quo_ff, quo_in;
   logic [2:0]            ovf_ff, ovf_in;

   logic [2:0][REM_W-1:0] shifted;
   logic [2:0][REM_W:0]   diff;

   // one restoring step per channel
   always_comb begin
      ctl_in = in_ctl;
      if (reset) begin
         ctl_in.valid = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         shifted[i] = {in_rem[i][REM_W-2:0], in_div[i][DIV_W-1]};
         diff[i]    = {1'b0, shifted[i]} - {2'b00, in_divisor};
         rem_in[i]  = diff[i][REM_W] ? shifted[i] : diff[i][REM_W-1:0];
         quo_in[i]  = {in_quo[i][QUO_W-2:0], ~diff[i][REM_W]};
         ovf_in[i]  = in_ovf[i] | in_quo[i][QUO_W-1];
         div_in[i]  = {in_div[i][DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         divisor_ff <= in_divisor;
         rem_ff     <= rem_in;
         div_ff     <= div_in;
         quo_ff     <= quo_in;
         ovf_ff     <= ovf_in;
      end
      if (advance || reset) begin
         ctl_ff <= ctl_in;
      end
   end

   assign out_ctl     = ctl_ff;
   assign out_divisor = divisor_ff;
   assign out_rem     = rem_ff;
   assign out_div     = div_ff;
   assign out_quo     = quo_ff;
   assign out_ovf     = ovf_ff;

endmodule

@@ rtl/disparity_to_point_reprojection_top.sv @@
`timescale 1ns / 1ps
// channel   ports                                   direction
// request   req_valid, req_ready, req               in
// result    rsp_valid, rsp_ready, rsp               out
// config    csr_write_en, csr_index, csr_data       in
//
// One request per cycle sustained while results are taken; a request with zero disparity yields no result.
// The pipeline has four front stages, then one divider cell per dividend bit
// (DIV_W = 49 at 16 fraction bits), then the result register.
// Synchronous reset clears valids and loads the register reset values.
// A stalled result freezes the chain; the input stage still takes one request.
module disparity_to_point_reprojection_top #(
   parameter int FRAC_BITS = rpj_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rpj_pkg::req_type                 req,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rpj_pkg::rsp_type                 rsp,
   input  logic                             csr_write_en,
   input  logic [rpj_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpj_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rpj_pkg::*;

   localparam int NUM_W = ((13 + FRAC_BITS) > 32 ? 13 + FRAC_BITS : 32) + 1;
   localparam int DIV_W = NUM_W + FRAC_BITS;

   logic signed [CSR_DATA_W-1:0] offset_x_ff, offset_y_ff, focal_length_ff;
   logic signed [CSR_DATA_W-1:0] inverse_baseline_ff, principal_shift_ff;

   logic                  advance;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_rsp_ff, out_rsp_in;

   cell_ctl_type          chain_ctl     [0:DIV_W];
   logic [WMAG_W-1:0]     chain_divisor [0:DIV_W];
   logic [2:0][REM_W-1:0] chain_rem     [0:DIV_W];
   logic [2:0][DIV_W-1:0] chain_div     [0:DIV_W];
   logic [2:0][QUO_W-1:0] chain_quo     [0:DIV_W];
   logic [2:0]            chain_ovf     [0:DIV_W];

   cell_ctl_type              last_ctl;
   logic [2:0][QUO_W-1:0]     last_quo;
   logic [2:0]                last_ovf;
   logic [2:0][COORD_W-1:0]   coord;
   logic                      sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff         <= '0;
         offset_y_ff         <= '0;
         focal_length_ff     <= CSR_DATA_W'(1) << FRAC_BITS;
         inverse_baseline_ff <= '0;
         principal_shift_ff  <= CSR_DATA_W'(1) << FRAC_BITS;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_OFFSET_X:         offset_x_ff         <= csr_data;
            CSR_OFFSET_Y:         offset_y_ff         <= csr_data;
            CSR_FOCAL_LENGTH:     focal_length_ff     <= csr_data;
            CSR_INVERSE_BASELINE: inverse_baseline_ff <= csr_data;
            CSR_PRINCIPAL_SHIFT:  principal_shift_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign advance = !out_valid_ff || rsp_ready;

   rpj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .req_valid        (req_valid),
      .req              (req),
      .req_ready        (req_ready),
      .offset_x         (offset_x_ff),
      .offset_y         (offset_y_ff),
      .focal_length     (focal_length_ff),
      .inverse_baseline (inverse_baseline_ff),
      .principal_shift  (principal_shift_ff),
      .out_ctl          (chain_ctl[0]),
      .out_divisor      (chain_divisor[0]),
      .out_div          (chain_div[0])
   );

   assign chain_rem[0] = '0;
   assign chain_quo[0] = '0;
   assign chain_ovf[0] = '0;

   for (genvar k = 0; k < DIV_W; k++) begin : g_cell
      rpj_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_ctl      (chain_ctl[k]),
         .in_divisor  (chain_divisor[k]),
         .in_rem      (chain_rem[k]),
         .in_div      (chain_div[k]),
         .in_quo      (chain_quo[k]),
         .in_ovf      (chain_ovf[k]),
         .out_ctl     (chain_ctl[k+1]),
         .out_divisor (chain_divisor[k+1]),
         .out_rem     (chain_rem[k+1]),
         .out_div     (chain_div[k+1]),
         .out_quo     (chain_quo[k+1]),
         .out_ovf     (chain_ovf[k+1])
      );
   end

   assign last_ctl = chain_ctl[DIV_W];
   assign last_quo = chain_quo[DIV_W];
   assign last_ovf = chain_ovf[DIV_W];

   // sign and clamp
   always_comb begin
      sat = last_ctl.w_zero;
      for (int i = 0; i < 3; i++) begin
         if (last_ctl.w_zero) begin
            if (last_ctl.num_zero[i]) begin
               coord[i] = '0;
            end else if (last_ctl.neg[i]) begin
               coord[i] = COORD_NEG_MAX;
            end else begin
               coord[i] = COORD_POS_MAX;
            end
         end else if (last_ctl.neg[i]) begin
            if (last_ovf[i] || last_quo[i][QUO_W-1] ||
                (last_quo[i][COORD_W-1] && (last_quo[i][COORD_W-2:0] != '0))) begin
               coord[i] = COORD_NEG_MAX;
               sat      = 1'b1;
            end else begin
               coord[i] = ~last_quo[i][COORD_W-1:0] + 1'b1;
            end
         end else begin
            if (last_ovf[i] || last_quo[i][QUO_W-1] || last_quo[i][COORD_W-1]) begin
               coord[i] = COORD_POS_MAX;
               sat      = 1'b1;
            end else begin
               coord[i] = last_quo[i][COORD_W-1:0];
            end
         end
      end
      out_rsp_in.point_x      = coord[0];
      out_rsp_in.point_y      = coord[1];
      out_rsp_in.point_z      = coord[2];
      out_rsp_in.packed_color = last_ctl.color;
      out_rsp_in.saturated    = sat;
      out_valid_in            = last_ctl.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_rsp_ff;

`ifndef SYNTH
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   a_chain_to_output: assert property (@(posedge clock) disable iff (reset)
      (last_ctl.valid && advance) |=> rsp_valid)
      else $error("result lost at chain end");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_zero_w_saturates: assert property (@(posedge clock) disable iff (reset)
      (last_ctl.valid && last_ctl.w_zero && advance) |=> rsp.saturated)
      else $error("zero denominator not flagged");
`endif

endmodule
